[rtl/core/led_matrix_bit_plane_mapper_top_macros.svh]
// ----------------------------------------------------------------------------
// led matrix bit-plane mapper assertion macros
// concurrent check wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_BIT_PLANE_MAPPER_TOP_MACROS_SVH
`define LED_MATRIX_BIT_PLANE_MAPPER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LBPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lbpm check failed");
// next-cycle implication
`define LBPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lbpm check failed");
`else
`define LBPM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LBPM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/lbpm_pkg.sv]
// ----------------------------------------------------------------------------
// lbpm_pkg
// shared widths, constants and request codes of the bit-plane mapper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lbpm_pkg;

    localparam int MATRIX_WIDTH  = 16;
    localparam int MATRIX_HEIGHT = 16;
    localparam int PWM_BITS      = 8;

    localparam int CHANNELS    = 4;
    localparam int CHAN_W      = 8;
    localparam int COLOR_W     = CHANNELS * CHAN_W;
    localparam int COORD_W     = 4;
    localparam int GAMMA_W     = 8;
    localparam int GAMMA_DEPTH = 256;
    localparam int GIDX_W      = 8;
    localparam int ADDR_W      = 10;
    localparam int NIBBLE_W    = 4;
    localparam int STEP_W      = (PWM_BITS > 1) ? $clog2(PWM_BITS) : 1;

    // distance between two bit planes in the frame buffer
    localparam int PLANE_WORDS = (MATRIX_WIDTH * MATRIX_HEIGHT) / 2;
    localparam logic [ADDR_W-1:0] PLANE_STRIDE = ADDR_W'(PLANE_WORDS);
    localparam logic [STEP_W-1:0] LAST_STEP    = STEP_W'(PWM_BITS - 1);

    typedef enum logic [0:0] {
        REQ_PIXEL = 1'b0,
        REQ_GAMMA = 1'b1
    } t_req_type;

endpackage

[rtl/core/lbpm_if.sv]
// ----------------------------------------------------------------------------
// lbpm channel interfaces
// request channel in, bit-plane write channel out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface lbpm_req_if;
    import lbpm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [COORD_W-1:0]   pix_x;
    logic [COORD_W-1:0]   pix_y;
    logic [COLOR_W-1:0]   pixel_color;
    logic [GIDX_W-1:0]    gamma_index;
    logic [GAMMA_W-1:0]   gamma_value;

    modport source (
        output valid, req_type, pix_x, pix_y, pixel_color, gamma_index, gamma_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, pix_x, pix_y, pixel_color, gamma_index, gamma_value,
        output ready
    );
endinterface

interface lbpm_plane_if;
    import lbpm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ADDR_W-1:0]    plane_address;
    logic [NIBBLE_W-1:0]  plane_nibble;
    logic                 lower_half;
    logic                 last_step;

    modport source (
        output valid, plane_address, plane_nibble, lower_half, last_step,
        input  ready
    );
    modport sink (
        input  valid, plane_address, plane_nibble, lower_half, last_step,
        output ready
    );
endinterface

[rtl/core/lbpm_ram.sv]
// ----------------------------------------------------------------------------
// lbpm_ram
// generic single-write, single-read ram with registered, held read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lbpm_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/led_matrix_bit_plane_mapper_top.sv]
// ----------------------------------------------------------------------------
// led_matrix_bit_plane_mapper_top
// maps one four-channel pixel into PWM bit-plane writes through a gamma table
// ----------------------------------------------------------------------------
//
//  channel   dir  modport               one request carries
//  -------   ---  -------------------   ------------------------------------
//  i_req     in   lbpm_req_if.sink      gamma entry write or pixel to map
//  o_plane   out  lbpm_plane_if.source  one bit-plane write per PWM step
//
//  a pixel gives PWM_BITS writes, one per cycle while o_plane is ready;
//  the step emitter walks them, and a gamma write is a single request.
//  order: accept, gamma read in the read stage, emitter load, first write.
//  the read stage refills while the emitter still drains the previous pixel,
//  so back-to-back pixels leave no gap on o_plane.
//  reset (synchronous, active low) clears only valid and step state; the
//  gamma table holds nothing until written and needs no clearing pass.
//  a stall on o_plane holds the current write and backs up into i_req.
//
`timescale 1ns / 1ps
`include "led_matrix_bit_plane_mapper_top_macros.svh"
module led_matrix_bit_plane_mapper_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    lbpm_req_if.sink            i_req,
    lbpm_plane_if.source        o_plane
);
    import lbpm_pkg::*;

    // ------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------
    logic w_in_acc;
    logic w_is_gamma;
    logic w_wr_en;
    logic w_rd_en;

    assign w_in_acc   = i_req.valid && i_req.ready;
    assign w_is_gamma = (i_req.req_type == REQ_GAMMA);
    assign w_wr_en    = w_in_acc && w_is_gamma;
    assign w_rd_en    = w_in_acc && !w_is_gamma;

    // ------------------------------------------------------------------
    // gamma table: one copy per channel so all four bytes look up at once
    // every copy takes every entry write
    // ------------------------------------------------------------------
    logic [GAMMA_W-1:0] w_gamma [CHANNELS];

    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lut
        lbpm_ram #(
            .WIDTH (GAMMA_W),
            .DEPTH (GAMMA_DEPTH)
        ) u_gamma_ram (
            .i_clk     (i_clk),
            .i_wr_en   (w_wr_en),
            .i_wr_addr (i_req.gamma_index),
            .i_wr_data (i_req.gamma_value),
            .i_rd_en   (w_rd_en),
            .i_rd_addr (i_req.pixel_color[ch*CHAN_W +: CHAN_W]),
            .o_rd_data (w_gamma[ch])
        );
    end

    // ------------------------------------------------------------------
    // read stage: pixel position waits here next to the gamma read data
    // ------------------------------------------------------------------
    logic              r_a_valid;
    logic [ADDR_W-1:0] r_a_tile;
    logic              r_a_half;
    logic              n_a_valid;
    logic [ADDR_W-1:0] n_a_tile;

    // ------------------------------------------------------------------
    // emitter stage: walks the PWM steps of one pixel
    // ------------------------------------------------------------------
    logic               r_c_valid;
    logic [STEP_W-1:0]  r_c_step;
    logic [ADDR_W-1:0]  r_c_addr;
    logic               r_c_half;
    logic [GAMMA_W-1:0] r_c_gamma [CHANNELS];
    logic               n_c_valid;
    logic [STEP_W-1:0]  n_c_step;
    logic [ADDR_W-1:0]  n_c_addr;
    logic [GAMMA_W-1:0] n_c_gamma [CHANNELS];

    logic w_last;
    logic w_out_acc;
    logic w_c_load;

    assign w_last    = (r_c_step == LAST_STEP);
    assign w_out_acc = r_c_valid && o_plane.ready;
    // emitter takes the next pixel when empty or finishing its last step
    assign w_c_load  = r_a_valid && (!r_c_valid || (w_out_acc && w_last));

    // read stage frees up in the cycle the emitter takes its pixel
    assign i_req.ready = !r_a_valid || w_c_load;

    // tile index: 16*(x/4) + 4*(y%4) + (x%4) + 64*(y/8), no carries between fields
    assign n_a_tile = ADDR_W'({i_req.pix_y[3], i_req.pix_x[3:2],
                               i_req.pix_y[1:0], i_req.pix_x[1:0]});

    always_comb begin
        n_a_valid = r_a_valid;
        if (w_c_load) begin
            n_a_valid = 1'b0;
        end
        if (w_rd_en) begin
            n_a_valid = 1'b1;
        end
    end

    always_comb begin
        n_c_valid = r_c_valid;
        n_c_step  = r_c_step;
        n_c_addr  = r_c_addr;
        n_c_gamma = r_c_gamma;
        if (w_c_load) begin
            n_c_valid = 1'b1;
            n_c_step  = '0;
            n_c_addr  = r_a_tile;
            n_c_gamma = w_gamma;
        end else if (w_out_acc) begin
            if (w_last) begin
                n_c_valid = 1'b0;
            end
            n_c_step = r_c_step + STEP_W'(1);
            // next plane, wraps over the buffer size
            n_c_addr = r_c_addr + PLANE_STRIDE;
            // shift so bit 0 is the next step's bit; zeros past the entry width
            for (int ch = 0; ch < CHANNELS; ch++) begin
                n_c_gamma[ch] = r_c_gamma[ch] >> 1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_c_step  <= '0;
        end else begin
            r_a_valid <= n_a_valid;
            r_c_valid <= n_c_valid;
            r_c_step  <= n_c_step;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_a_tile <= n_a_tile;
            r_a_half <= i_req.pix_y[2];
        end
        if (w_c_load) begin
            r_c_half <= r_a_half;
        end
        r_c_addr  <= n_c_addr;
        r_c_gamma <= n_c_gamma;
    end

    // ------------------------------------------------------------------
    // outputs: channel 0 lands on nibble bit 3
    // ------------------------------------------------------------------
    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            o_plane.plane_nibble[NIBBLE_W-1-ch] = r_c_gamma[ch][0];
        end
    end

    assign o_plane.valid         = r_c_valid;
    assign o_plane.plane_address = r_c_addr;
    assign o_plane.lower_half    = r_c_half;
    assign o_plane.last_step     = w_last;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `LBPM_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !r_a_valid, i_req.ready)
    `LBPM_ASSERT_NEXT(a_step_advance, i_clk, i_rst_n, w_out_acc && !w_last,
        r_c_valid && (r_c_step == $past(r_c_step) + STEP_W'(1)))
    `LBPM_ASSERT_NEXT(a_addr_stride, i_clk, i_rst_n, w_out_acc && !w_last,
        r_c_addr == $past(r_c_addr) + PLANE_STRIDE)
    `LBPM_ASSERT_NEXT(a_drain_on_last, i_clk, i_rst_n, w_out_acc && w_last && !r_a_valid,
        !r_c_valid)
    `LBPM_ASSERT_NEXT(a_load_first_step, i_clk, i_rst_n, w_c_load,
        r_c_valid && (r_c_step == '0))

endmodule
